/* rtl/cle_pkg.sv */
// Shared types and constants for the circular list engine.
// It has no dependencies. Every RTL file of the block refers to it by scoped names.
package cle_pkg;

   // This is the default number of slots in the pool.
   localparam int CapacityDefault = 16;

   // This is the width of a stored value.
   localparam int ValueWidth = 32;

   // These are the command codes of a request beat.
   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_TRAVERSE = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   // These are the status codes of a response beat.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // This is the request beat.
   typedef struct packed {
      cmd_type                       command;
      logic signed [ValueWidth-1:0]  value;
   } req_type;

   // This is the response beat.
   typedef struct packed {
      logic signed [ValueWidth-1:0]  item_value;
      status_type                    status;
      logic                          last;
   } rsp_type;

endpackage

/* rtl/circular_list_engine_unit.sv */
// Top level of the circular list engine: a bounded circular doubly linked list.
// It uses cle_pkg for the beat structs, the command and status codes and the defaults.
//
// Channel   Direction   Handshake             Payload
// req_      in          req_valid/req_stall   cle_pkg::req_type (command, value)
// rsp_      out         rsp_valid/rsp_stall   cle_pkg::rsp_type (item_value, status, last)
//
// Steps: insert passes through a link state when it links behind existing entries, else it
// goes straight to its status beat (an empty list or a full pool). Clear goes straight to its
// status beat. Delete compares entries one at a time. Traverse gives one beat a cycle while the
// output is not stalled. The rate is set by the single read port of the slot memories, which
// follows one link each cycle.
// Reset is synchronous. It clears the control state and the free map only. The slot memories
// are not initialised and need no clearing pass.
// A request is taken only while the engine is idle. A stalled response holds the traverse
// walk in place. A finished response beat may wait while the next request is taken.
module circular_list_engine_unit #(
   parameter int CAPACITY = cle_pkg::CapacityDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cle_pkg::rsp_type rsp_data
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = cle_pkg::ValueWidth;
   localparam logic [CW-1:0]       CNT_ONE  = CW'(1);
   localparam logic [CW-1:0]       CNT_FULL = CW'(CAPACITY);
   localparam logic [CAPACITY-1:0] SLOT_ONE = CAPACITY'(1);

   // These are the sequencer states, with one-hot codes.
   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_INS_LINK = 5'b00010,
      S_DEL_SCAN = 5'b00100,
      S_TRV_EMIT = 5'b01000,
      S_EMIT     = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [SW-1:0]           head_ff, head_in;
   logic [SW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CAPACITY-1:0]     free_ff, free_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [SW-1:0]           cur_ff, cur_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic signed [VW-1:0]    key_ff, key_in;
   cle_pkg::status_type     pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cle_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   // These are the slot memories and their registered read data.
   logic signed [VW-1:0]    value_mem_ff [CAPACITY];
   logic [SW-1:0]           next_mem_ff  [CAPACITY];
   logic [SW-1:0]           prev_mem_ff  [CAPACITY];
   logic signed [VW-1:0]    rd_value_ff;
   logic [SW-1:0]           rd_next_ff;
   logic [SW-1:0]           rd_prev_ff;

   logic                    val_we, nxt_we, prv_we, rd_en;
   logic [SW-1:0]           val_wa, nxt_wa, prv_wa, rd_addr;
   logic signed [VW-1:0]    val_wd;
   logic [SW-1:0]           nxt_wd, prv_wd;
   logic [SW-1:0]           free_slot;
   logic                    can_push;
   logic                    walk_last;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign can_push  = !rsp_valid_ff || !rsp_stall;
   assign walk_last = (idx_ff == count_ff - CNT_ONE);

   // The lowest free slot is found by a priority search over the free map.
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   // The sequencer reads, modifies and writes back the slot memories.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      val_we       = 1'b0;
      val_wa       = '0;
      val_wd       = '0;
      nxt_we       = 1'b0;
      nxt_wa       = '0;
      nxt_wd       = '0;
      prv_we       = 1'b0;
      prv_wa       = '0;
      prv_wd       = '0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_data.value;
               unique case (req_data.command)
                  cle_pkg::CMD_INSERT: begin
                     state_in = S_EMIT;
                     if (count_ff >= CNT_FULL) begin
                        pend_in = cle_pkg::ST_FULL;
                     end else begin
                        pend_in  = cle_pkg::ST_OK;
                        slot_in  = free_slot;
                        free_in  = free_ff & ~(SLOT_ONE << free_slot);
                        count_in = count_ff + CNT_ONE;
                        val_we   = 1'b1;
                        val_wa   = free_slot;
                        val_wd   = req_data.value;
                        nxt_we   = 1'b1;
                        nxt_wa   = free_slot;
                        prv_we   = 1'b1;
                        prv_wa   = free_slot;
                        if (count_ff == '0) begin
                           // The first entry links to itself.
                           nxt_wd  = free_slot;
                           prv_wd  = free_slot;
                           head_in = free_slot;
                           tail_in = free_slot;
                        end else begin
                           nxt_wd   = head_ff;
                           prv_wd   = tail_ff;
                           state_in = S_INS_LINK;
                        end
                     end
                  end
                  cle_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        pend_in  = cle_pkg::ST_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        cur_in   = head_ff;
                        idx_in   = '0;
                        state_in = S_DEL_SCAN;
                     end
                  end
                  cle_pkg::CMD_TRAVERSE: begin
                     if (count_ff == '0) begin
                        pend_in  = cle_pkg::ST_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        cur_in   = head_ff;
                        idx_in   = '0;
                        state_in = S_TRV_EMIT;
                     end
                  end
                  cle_pkg::CMD_CLEAR: begin
                     state_in = S_EMIT;
                     if (count_ff == '0) begin
                        pend_in = cle_pkg::ST_EMPTY;
                     end else begin
                        pend_in  = cle_pkg::ST_OK;
                        free_in  = '1;
                        head_in  = '0;
                        count_in = '0;
                     end
                  end
               endcase
            end
         end

         // The old tail and the head now point at the new slot.
         S_INS_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = tail_ff;
            nxt_wd   = slot_ff;
            prv_we   = 1'b1;
            prv_wa   = head_ff;
            prv_wd   = slot_ff;
            tail_in  = slot_ff;
            pend_in  = cle_pkg::ST_OK;
            state_in = S_EMIT;
         end

         // One slot is compared each cycle. A match is unlinked in a single write to each
         // link memory, unless it was the only entry.
         S_DEL_SCAN: begin
            if (rd_value_ff == key_ff) begin
               free_in  = free_ff | (SLOT_ONE << cur_ff);
               count_in = count_ff - CNT_ONE;
               pend_in  = cle_pkg::ST_OK;
               state_in = S_EMIT;
               if (count_ff == CNT_ONE) begin
                  head_in = '0;
               end else begin
                  if (cur_ff == head_ff) begin
                     head_in = rd_next_ff;
                  end
                  if (cur_ff == tail_ff) begin
                     tail_in = rd_prev_ff;
                  end
                  nxt_we = 1'b1;
                  nxt_wa = rd_prev_ff;
                  nxt_wd = rd_next_ff;
                  prv_we = 1'b1;
                  prv_wa = rd_next_ff;
                  prv_wd = rd_prev_ff;
               end
            end else if (walk_last) begin
               pend_in  = cle_pkg::ST_NOTFOUND;
               state_in = S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = rd_next_ff;
               cur_in  = rd_next_ff;
               idx_in  = idx_ff + CNT_ONE;
            end
         end

         // Each entry goes out as a beat. The walk holds while the output is stalled.
         S_TRV_EMIT: begin
            if (can_push) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.item_value  = rd_value_ff;
               rsp_data_in.status      = cle_pkg::ST_OK;
               rsp_data_in.last        = walk_last;
               if (walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rd_next_ff;
                  cur_in  = rd_next_ff;
                  idx_in  = idx_ff + CNT_ONE;
               end
            end
         end

         // A single status beat closes the command.
         S_EMIT: begin
            if (can_push) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.item_value = '0;
               rsp_data_in.status     = pend_ff;
               rsp_data_in.last       = 1'b1;
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // These are the control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // These are the payload and working registers. They need no reset.
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // This is the value memory, with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem_ff[val_wa] <= val_wd;
      end
      if (rd_en) begin
         rd_value_ff <= value_mem_ff[rd_addr];
      end
   end

   // This is the next-link memory.
   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem_ff[nxt_wa] <= nxt_wd;
      end
      if (rd_en) begin
         rd_next_ff <= next_mem_ff[rd_addr];
      end
   end

   // This is the previous-link memory.
   always_ff @(posedge clock) begin
      if (prv_we) begin
         prev_mem_ff[prv_wa] <= prv_wd;
      end
      if (rd_en) begin
         rd_prev_ff <= prev_mem_ff[rd_addr];
      end
   end

endmodule
